[design/sha256_keystream_xor_tag_macros.svh]
// assertion macros shared by the keystream block modules
// no dependencies; included by files that carry assertions
`ifndef SHA256_KEYSTREAM_XOR_TAG_MACROS_SVH
`define SHA256_KEYSTREAM_XOR_TAG_MACROS_SVH

// checked property, masked while reset is high
`define SKXT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked property, live during reset as well
`define SKXT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/skxt_pkg.sv]
// types, constants and helper functions for the sha-256 keystream block
// used by skxt_compress and sha256_keystream_xor_tag
package skxt_pkg;

   typedef logic [7:0][31:0]  chain_type;
   typedef logic [15:0][31:0] block_type;
   typedef logic [63:0][7:0]  bytes_type;

   localparam chain_type H_INIT = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

   localparam logic [31:0] K_ROUND [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam logic [3:0] CSR_KEY0      = 4'd0;
   localparam logic [3:0] CSR_KEY1      = 4'd1;
   localparam logic [3:0] CSR_KEY2      = 4'd2;
   localparam logic [3:0] CSR_KEY3      = 4'd3;
   localparam logic [3:0] CSR_SALT_LOW  = 4'd4;
   localparam logic [3:0] CSR_SALT_HIGH = 4'd5;
   localparam logic [3:0] CSR_DECRYPT   = 4'd6;
   localparam logic [3:0] CSR_EXP_TAG   = 4'd7;

   localparam logic [7:0] PAD_MARK    = 8'h80;
   localparam logic [5:0] PREFIX_LAST = 6'd43;
   localparam logic [5:0] LEN_POS     = 6'd56;
   localparam logic [5:0] BLOCK_LAST  = 6'd63;
   // bit lengths of the two short hashes (44 and 36 bytes)
   localparam logic [15:0] BASE_BITS  = 16'd352;
   localparam logic [15:0] CHUNK_BITS = 16'd288;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      logic [63:0] d;
      d = {x, x} >> n;
      return d[31:0];
   endfunction

   // byte 0 is the most significant byte of word 0
   function automatic block_type pack_block(input bytes_type b);
      block_type w;
      for (int j = 0; j < 16; j++) begin
         w[j] = {b[4*j], b[4*j+1], b[4*j+2], b[4*j+3]};
      end
      return w;
   endfunction

   // digest in byte order, byte i at bits 8i
   function automatic logic [255:0] digest_bytes(input chain_type h);
      logic [255:0] r;
      for (int i = 0; i < 32; i++) begin
         r[8*i +: 8] = h[i/4][8*(3-(i%4)) +: 8];
      end
      return r;
   endfunction

endpackage

[design/sha256_keystream_xor_tag.sv]
// keystream xor with running sha-256 tag: sequencer, pads, tag block and csr
// depends on skxt_pkg, skxt_compress and the assertion macro header
//
//   channel | dir | handshake          | payload
//   req     | in  | req_valid/stall    | data_byte, last_byte
//   rsp     | out | rsp_valid/stall    | out_byte, out_last, tag, tag_match
//   csr     | in  | csr_valid/ready    | index, data
//
// one sha-256 compression unit does all hashing
// a byte adds a compression at each chunk start and each 64th tag byte
// first byte of a message adds the base pad hash and the 44-byte prefix
// last byte adds tag padding and final compressions
// reset is synchronous; the result waits in an output register while rsp is stalled
`include "sha256_keystream_xor_tag_macros.svh"

module sha256_keystream_xor_tag (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_last,
   output logic [63:0] rsp_tag,
   output logic        rsp_tag_match,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [63:0] csr_data
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_HGO   = 8'b0000_0010,
      ST_HWAIT = 8'b0000_0100,
      ST_PRE   = 8'b0000_1000,
      ST_CHK   = 8'b0001_0000,
      ST_XOR   = 8'b0010_0000,
      ST_FILL  = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   typedef enum logic [2:0] {
      KIND_BASE  = 3'b001,
      KIND_CHUNK = 3'b010,
      KIND_TAG   = 3'b100
   } kind_type;

   typedef enum logic [2:0] {
      PH_MARK = 3'b001,
      PH_ZERO = 3'b010,
      PH_LEN  = 3'b100
   } phase_type;

   // configuration
   logic [63:0] key0_ff, key1_ff, key2_ff, key3_ff, salt_low_ff, exp_tag_ff;
   logic [31:0] salt_high_ff;
   logic        decrypt_ff;

   state_type           state_ff, state_in;
   kind_type            kind_ff, kind_in;
   phase_type           phase_ff, phase_in;
   logic                in_message_ff, in_message_in;
   logic [31:0]         chunk_number_ff, chunk_number_in;
   logic [4:0]          bic_ff, bic_in;
   logic [31:0]         len_ff, len_in;
   logic [5:0]          fptr_ff, fptr_in;
   logic [5:0]          pcnt_ff, pcnt_in;
   logic [7:0]          din_ff, din_in;
   logic                last_ff, last_in;
   logic [255:0]        base_pad_ff, base_pad_in;
   logic [255:0]        chunk_pad_ff, chunk_pad_in;
   skxt_pkg::chain_type tag_chain_ff, tag_chain_in;
   skxt_pkg::block_type tw_ff, tw_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_byte_ff, rsp_byte_in;
   logic                rsp_last_ff, rsp_last_in;
   logic [63:0]         rsp_tag_ff, rsp_tag_in;
   logic                rsp_match_ff, rsp_match_in;

   logic                comp_start, comp_done, tw_we;
   logic [7:0]          wr_byte, dout_c;
   skxt_pkg::chain_type comp_chain, comp_digest;
   skxt_pkg::block_type comp_block;
   skxt_pkg::bytes_type base_bytes, chunk_bytes;
   logic [351:0]        prefix_flat;
   logic [63:0]         len_bits;
   logic [255:0]        tag_flat;

   assign prefix_flat = {salt_high_ff, salt_low_ff, key3_ff, key2_ff, key1_ff, key0_ff};
   assign len_bits    = {29'd0, len_ff, 3'd0};
   assign tag_flat    = skxt_pkg::digest_bytes(tag_chain_ff);
   assign dout_c      = din_ff ^ chunk_pad_ff[{bic_ff, 3'd0} +: 8];

   always_comb begin
      base_bytes  = '0;
      chunk_bytes = '0;
      for (int i = 0; i < 44; i++) begin
         base_bytes[i] = prefix_flat[8*i +: 8];
      end
      base_bytes[44] = skxt_pkg::PAD_MARK;
      base_bytes[62] = skxt_pkg::BASE_BITS[15:8];
      base_bytes[63] = skxt_pkg::BASE_BITS[7:0];
      for (int i = 0; i < 32; i++) begin
         chunk_bytes[i] = base_pad_ff[8*i +: 8];
      end
      for (int i = 0; i < 4; i++) begin
         chunk_bytes[32+i] = chunk_number_ff[8*i +: 8];
      end
      chunk_bytes[36] = skxt_pkg::PAD_MARK;
      chunk_bytes[62] = skxt_pkg::CHUNK_BITS[15:8];
      chunk_bytes[63] = skxt_pkg::CHUNK_BITS[7:0];
   end

   always_comb begin
      unique case (kind_ff)
         KIND_BASE: begin
            comp_block = skxt_pkg::pack_block(base_bytes);
            comp_chain = skxt_pkg::H_INIT;
         end
         KIND_CHUNK: begin
            comp_block = skxt_pkg::pack_block(chunk_bytes);
            comp_chain = skxt_pkg::H_INIT;
         end
         KIND_TAG: begin
            comp_block = tw_ff;
            comp_chain = tag_chain_ff;
         end
         default: begin
            comp_block = tw_ff;
            comp_chain = tag_chain_ff;
         end
      endcase
   end

   skxt_compress u_compress (
      .clock      (clock),
      .reset      (reset),
      .start      (comp_start),
      .chain_in   (comp_chain),
      .block_in   (comp_block),
      .done       (comp_done),
      .digest_out (comp_digest)
   );

   always_comb begin
      state_in        = state_ff;
      kind_in         = kind_ff;
      phase_in        = phase_ff;
      in_message_in   = in_message_ff;
      chunk_number_in = chunk_number_ff;
      bic_in          = bic_ff;
      len_in          = len_ff;
      fptr_in         = fptr_ff;
      pcnt_in         = pcnt_ff;
      din_in          = din_ff;
      last_in         = last_ff;
      base_pad_in     = base_pad_ff;
      chunk_pad_in    = chunk_pad_ff;
      tag_chain_in    = tag_chain_ff;
      tw_in           = tw_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_byte_in     = rsp_byte_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_tag_in      = rsp_tag_ff;
      rsp_match_in    = rsp_match_ff;
      comp_start      = 1'b0;
      tw_we           = 1'b0;
      wr_byte         = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               din_in   = req_data_byte;
               last_in  = req_last_byte;
               phase_in = PH_MARK;
               if (!in_message_ff) begin
                  kind_in  = KIND_BASE;
                  state_in = ST_HGO;
               end else begin
                  state_in = ST_CHK;
               end
            end
         end
         ST_HGO: begin
            comp_start = 1'b1;
            state_in   = ST_HWAIT;
         end
         ST_HWAIT: begin
            if (comp_done) begin
               unique case (kind_ff)
                  KIND_BASE: begin
                     base_pad_in  = skxt_pkg::digest_bytes(comp_digest);
                     tag_chain_in = skxt_pkg::H_INIT;
                     len_in       = '0;
                     fptr_in      = '0;
                     pcnt_in      = '0;
                     state_in     = ST_PRE;
                  end
                  KIND_CHUNK: begin
                     chunk_pad_in = skxt_pkg::digest_bytes(comp_digest);
                     state_in     = ST_XOR;
                  end
                  default: begin
                     tag_chain_in = comp_digest;
                     priority if (phase_ff == PH_LEN) begin
                        state_in = ST_DONE;
                     end else if (last_ff) begin
                        state_in = ST_FILL;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
               endcase
            end
         end
         ST_PRE: begin
            // key and salt go into the tag hash one byte a cycle
            tw_we   = 1'b1;
            wr_byte = prefix_flat[{pcnt_ff, 3'd0} +: 8];
            len_in  = len_ff + 32'd1;
            fptr_in = fptr_ff + 6'd1;
            pcnt_in = pcnt_ff + 6'd1;
            if (pcnt_ff == skxt_pkg::PREFIX_LAST) begin
               chunk_number_in = '0;
               bic_in          = '0;
               in_message_in   = 1'b1;
               state_in        = ST_CHK;
            end
         end
         ST_CHK: begin
            if (bic_ff == 5'd0) begin
               chunk_number_in = chunk_number_ff + 32'd1;
               kind_in         = KIND_CHUNK;
               state_in        = ST_HGO;
            end else begin
               state_in = ST_XOR;
            end
         end
         ST_XOR: begin
            tw_we   = 1'b1;
            wr_byte = decrypt_ff ? dout_c : din_ff;
            // din_ff holds the output byte from here until the result is loaded
            din_in  = dout_c;
            len_in  = len_ff + 32'd1;
            fptr_in = fptr_ff + 6'd1;
            bic_in  = bic_ff + 5'd1;
            priority if (fptr_ff == skxt_pkg::BLOCK_LAST) begin
               kind_in  = KIND_TAG;
               state_in = ST_HGO;
            end else if (last_ff) begin
               state_in = ST_FILL;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_FILL: begin
            unique case (phase_ff)
               PH_MARK: begin
                  tw_we    = 1'b1;
                  wr_byte  = skxt_pkg::PAD_MARK;
                  phase_in = PH_ZERO;
               end
               PH_ZERO: begin
                  if (fptr_ff == skxt_pkg::LEN_POS) begin
                     phase_in = PH_LEN;
                  end else begin
                     tw_we = 1'b1;
                  end
               end
               default: begin
                  tw_we   = 1'b1;
                  wr_byte = len_bits[{~fptr_ff[2:0], 3'd0} +: 8];
               end
            endcase
            if (tw_we) begin
               fptr_in = fptr_ff + 6'd1;
               if (fptr_ff == skxt_pkg::BLOCK_LAST) begin
                  kind_in  = KIND_TAG;
                  state_in = ST_HGO;
               end
            end
         end
         default: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = din_ff;
               rsp_last_in  = last_ff;
               rsp_tag_in   = last_ff ? tag_flat[63:0] : 64'd0;
               rsp_match_in = last_ff && decrypt_ff && (tag_flat[63:0] == exp_tag_ff);
               if (last_ff) begin
                  in_message_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
      endcase

      if (tw_we) begin
         tw_in[fptr_ff[5:2]][{~fptr_ff[1:0], 3'd0} +: 8] = wr_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         kind_ff         <= KIND_BASE;
         phase_ff        <= PH_MARK;
         in_message_ff   <= 1'b0;
         chunk_number_ff <= '0;
         bic_ff          <= '0;
         len_ff          <= '0;
         fptr_ff         <= '0;
         pcnt_ff         <= '0;
         tag_chain_ff    <= skxt_pkg::H_INIT;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         kind_ff         <= kind_in;
         phase_ff        <= phase_in;
         in_message_ff   <= in_message_in;
         chunk_number_ff <= chunk_number_in;
         bic_ff          <= bic_in;
         len_ff          <= len_in;
         fptr_ff         <= fptr_in;
         pcnt_ff         <= pcnt_in;
         tag_chain_ff    <= tag_chain_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      din_ff       <= din_in;
      last_ff      <= last_in;
      base_pad_ff  <= base_pad_in;
      chunk_pad_ff <= chunk_pad_in;
      tw_ff        <= tw_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_match_ff <= rsp_match_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff      <= '0;
         key1_ff      <= '0;
         key2_ff      <= '0;
         key3_ff      <= '0;
         salt_low_ff  <= '0;
         salt_high_ff <= '0;
         decrypt_ff   <= 1'b0;
         exp_tag_ff   <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            skxt_pkg::CSR_KEY0:      key0_ff      <= csr_data;
            skxt_pkg::CSR_KEY1:      key1_ff      <= csr_data;
            skxt_pkg::CSR_KEY2:      key2_ff      <= csr_data;
            skxt_pkg::CSR_KEY3:      key3_ff      <= csr_data;
            skxt_pkg::CSR_SALT_LOW:  salt_low_ff  <= csr_data;
            skxt_pkg::CSR_SALT_HIGH: salt_high_ff <= csr_data[31:0];
            skxt_pkg::CSR_DECRYPT:   decrypt_ff   <= csr_data[0];
            skxt_pkg::CSR_EXP_TAG:   exp_tag_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   assign csr_ready     = 1'b1;
   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_out_last  = rsp_last_ff;
   assign rsp_tag       = rsp_tag_ff;
   assign rsp_tag_match = rsp_match_ff;

   `SKXT_ASSERT(a_done_in_wait, clock, reset, comp_done |-> state_ff == ST_HWAIT, "hash done outside wait")
   `SKXT_ASSERT(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE, "result without done state")
   `SKXT_ASSERT(a_prefix_new_msg, clock, reset, state_ff == ST_PRE |-> !in_message_ff, "prefix absorbed inside a message")
   `SKXT_ASSERT(a_match_needs_last, clock, reset, rsp_valid_ff && rsp_tag_match |-> rsp_out_last, "tag match on a middle item")

endmodule

[design/skxt_compress.sv]
// iterative sha-256 compression, one round per cycle, 16-word schedule window
// depends on skxt_pkg and the assertion macro header
`include "sha256_keystream_xor_tag_macros.svh"

module skxt_compress (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  skxt_pkg::chain_type chain_in,
   input  skxt_pkg::block_type block_in,
   output logic               done,
   output skxt_pkg::chain_type digest_out
);

   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic [5:0]          cnt_ff, cnt_in;
   skxt_pkg::chain_type v_ff, v_in;
   skxt_pkg::block_type w_ff, w_in;

   logic [31:0] s0, s1, w_next, big_s0, big_s1, ch, maj, t1, t2;

   always_comb begin
      s0 = skxt_pkg::rotr(w_ff[1], 7) ^ skxt_pkg::rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = skxt_pkg::rotr(w_ff[14], 17) ^ skxt_pkg::rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      w_next = w_ff[0] + s0 + w_ff[9] + s1;
      big_s1 = skxt_pkg::rotr(v_ff[4], 6) ^ skxt_pkg::rotr(v_ff[4], 11)
             ^ skxt_pkg::rotr(v_ff[4], 25);
      ch = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1 = v_ff[7] + big_s1 + ch + skxt_pkg::K_ROUND[cnt_ff] + w_ff[0];
      big_s0 = skxt_pkg::rotr(v_ff[0], 2) ^ skxt_pkg::rotr(v_ff[0], 13)
             ^ skxt_pkg::rotr(v_ff[0], 22);
      maj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2 = big_s0 + maj;

      run_in  = run_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      v_in    = v_ff;
      w_in    = w_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         v_in   = chain_in;
         w_in   = block_in;
      end else if (run_ff) begin
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
         for (int j = 0; j < 15; j++) begin
            w_in[j] = w_ff[j+1];
         end
         w_in[15] = w_next;
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == skxt_pkg::BLOCK_LAST) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      v_ff <= v_in;
      w_ff <= w_in;
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         digest_out[i] = chain_in[i] + v_ff[i];
      end
   end

   assign done = done_ff;

   `SKXT_ASSERT(a_no_restart, clock, reset, start |-> !run_ff, "start while rounds run")
   `SKXT_ASSERT(a_done_on_end, clock, reset, $fell(run_ff) |-> done_ff, "rounds ended without done")
   `SKXT_ASSERT(a_idle_count, clock, reset, !run_ff |-> cnt_ff == 6'd0, "round count not parked")

endmodule

[sim/testbench.sv]
// self-checking testbench for sha256_keystream_xor_tag: random messages, csr settings, stalls
// depends on skxt_pkg (csr indexes) and the block itself; predicts every result in-line
module testbench;

   typedef logic [7:0][31:0] chain_type;
   typedef logic [63:0][7:0] blk_type;
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } byte_item_type;
   typedef struct packed {
      logic [7:0]  out_byte;
      logic        out_last;
      logic [63:0] tag;
      logic        tag_match;
   } cipher_out_type;

   localparam logic [3:0] CSR_SPARE_LO = 4'd8;
   localparam logic [3:0] CSR_SPARE_HI = 4'd15;

   localparam logic [31:0] RK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
   localparam chain_type IV = {32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
                               32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = '0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_out_last;
   logic [63:0] rsp_tag;
   logic        rsp_tag_match;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   sha256_keystream_xor_tag i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow registers and cipher state
   logic [63:0]  key_w [4];
   logic [63:0]  salt_lo;
   logic [31:0]  salt_hi;
   logic         decrypt;
   logic [63:0]  rx_tag;
   logic [255:0] base_pad, chunk_pad;
   logic [31:0]  chunk_no, msg_len;
   logic [4:0]   chunk_pos;
   chain_type    mac_chain;
   blk_type      mac_block;
   logic         msg_open;

   byte_item_type  pending_bytes[$];
   cipher_out_type expected_out[$];
   int             fail_count = 0;
   int             hold_request = 0;
   logic           taken = 1'b0;

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic chain_type sha_compress(input chain_type h, input blk_type b);
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2, s0, s1;
      chain_type r;
      for (int i = 0; i < 16; i++) w[i] = {b[4*i], b[4*i+1], b[4*i+2], b[4*i+3]};
      for (int i = 16; i < 64; i++) begin
         s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      for (int i = 0; i < 8; i++) v[i] = h[i];
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
              ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[i] + w[i];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
              ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) r[i] = h[i] + v[i];
      return r;
   endfunction

   // single-block digest of a short message, byte i of the digest at bits 8i
   function automatic logic [255:0] short_digest(input blk_type msg, input int len);
      blk_type b;
      chain_type h;
      logic [63:0] bits;
      logic [255:0] d;
      b = '0;
      for (int i = 0; i < len; i++) b[i] = msg[i];
      b[len] = 8'h80;
      bits = len * 8;
      for (int i = 0; i < 8; i++) b[56+i] = bits[8*(7-i) +: 8];
      h = sha_compress(IV, b);
      for (int i = 0; i < 32; i++) d[8*i +: 8] = h[i/4][8*(3-(i%4)) +: 8];
      return d;
   endfunction

   function automatic void mac_absorb(input logic [7:0] b);
      mac_block[msg_len[5:0]] = b;
      msg_len = msg_len + 1;
      if (msg_len[5:0] == 6'd0) mac_chain = sha_compress(mac_chain, mac_block);
   endfunction

   function automatic logic [63:0] mac_finish();
      int idx;
      logic [63:0] bits, t;
      idx = msg_len[5:0];
      mac_block[idx] = 8'h80;
      idx++;
      if (idx > 56) begin
         for (int i = idx; i < 64; i++) mac_block[i] = 8'h00;
         mac_chain = sha_compress(mac_chain, mac_block);
         idx = 0;
      end
      for (int i = idx; i < 56; i++) mac_block[i] = 8'h00;
      bits = {32'd0, msg_len} << 3;
      for (int i = 0; i < 8; i++) mac_block[56+i] = bits[8*(7-i) +: 8];
      mac_chain = sha_compress(mac_chain, mac_block);
      for (int i = 0; i < 8; i++) t[8*i +: 8] = mac_chain[i/4][8*(3-(i%4)) +: 8];
      return t;
   endfunction

   function automatic cipher_out_type encipher_byte(input byte_item_type it);
      blk_type src;
      cipher_out_type r;
      logic [7:0] ob;
      if (!msg_open) begin
         src = '0;
         for (int i = 0; i < 32; i++) src[i] = key_w[i/8][8*(i%8) +: 8];
         for (int i = 0; i < 8; i++) src[32+i] = salt_lo[8*i +: 8];
         for (int i = 0; i < 4; i++) src[40+i] = salt_hi[8*i +: 8];
         base_pad = short_digest(src, 44);
         mac_chain = IV;
         msg_len = 0;
         for (int i = 0; i < 44; i++) mac_absorb(src[i]);
         chunk_no = 0;
         chunk_pos = 0;
         msg_open = 1'b1;
      end
      if (chunk_pos == 5'd0) begin
         chunk_no = chunk_no + 1;
         src = '0;
         for (int i = 0; i < 32; i++) src[i] = base_pad[8*i +: 8];
         for (int i = 0; i < 4; i++) src[32+i] = chunk_no[8*i +: 8];
         chunk_pad = short_digest(src, 36);
      end
      ob = it.data ^ chunk_pad[8*chunk_pos +: 8];
      chunk_pos = chunk_pos + 1;
      mac_absorb(decrypt ? ob : it.data);
      r.out_byte = ob;
      r.out_last = it.last;
      r.tag = '0;
      r.tag_match = 1'b0;
      if (it.last) begin
         r.tag = mac_finish();
         r.tag_match = decrypt && (r.tag == rx_tag);
         msg_open = 1'b0;
      end
      return r;
   endfunction

   function automatic void apply_reg(input logic [3:0] idx, input logic [63:0] d);
      case (idx)
         skxt_pkg::CSR_KEY0:      key_w[0] = d;
         skxt_pkg::CSR_KEY1:      key_w[1] = d;
         skxt_pkg::CSR_KEY2:      key_w[2] = d;
         skxt_pkg::CSR_KEY3:      key_w[3] = d;
         skxt_pkg::CSR_SALT_LOW:  salt_lo = d;
         skxt_pkg::CSR_SALT_HIGH: salt_hi = d[31:0];
         skxt_pkg::CSR_DECRYPT:   decrypt = d[0];
         skxt_pkg::CSR_EXP_TAG:   rx_tag = d;
         default: ;
      endcase
   endfunction

   // acceptance, prediction and checking all on the rising edge
   always @(posedge clock) begin
      cipher_out_type exp_r;
      if (reset) begin
         taken <= 1'b0;
      end else begin
         taken <= req_valid && !req_stall;
         if (req_valid && !req_stall)
            expected_out.push_back(encipher_byte('{req_data_byte, req_last_byte}));
         if (rsp_valid && !rsp_stall) begin
            if (expected_out.size() == 0) begin
               $error("result item with nothing expected");
               fail_count++;
            end else begin
               exp_r = expected_out.pop_front();
               if (rsp_out_byte !== exp_r.out_byte) begin
                  $error("out_byte expected %h got %h", exp_r.out_byte, rsp_out_byte);
                  fail_count++;
               end
               if (rsp_out_last !== exp_r.out_last) begin
                  $error("out_last expected %b got %b", exp_r.out_last, rsp_out_last);
                  fail_count++;
               end
               if (rsp_tag !== exp_r.tag) begin
                  $error("tag expected %h got %h", exp_r.tag, rsp_tag);
                  fail_count++;
               end
               if (rsp_tag_match !== exp_r.tag_match) begin
                  $error("tag_match expected %b got %b", exp_r.tag_match, rsp_tag_match);
                  fail_count++;
               end
            end
         end
      end
   end

   // sender: bursts with random gaps, payload held while stalled
   int burst_left = 8, gap_left = 0;
   always @(negedge clock) begin
      byte_item_type it;
      if (!reset && (!req_valid || taken)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            it = pending_bytes.pop_front();
            req_data_byte <= it.data;
            req_last_byte <= it.last;
            req_valid <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 60);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: stall pattern changing every so often, plus one long hold-off
   int stall_mode = 0, mode_left = 50, hold_left = 0;
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_request != 0) begin
         hold_request = 0;
         hold_left = 600;
         rsp_stall <= 1'b1;
      end else begin
         mode_left--;
         if (mode_left <= 0) begin
            mode_left = $urandom_range(20, 200);
            stall_mode = $urandom_range(0, 2);
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 9) < 3);
            default: rsp_stall <= ($urandom_range(0, 9) < 7);
         endcase
      end
   end

   task automatic write_reg(input logic [3:0] idx, input logic [63:0] d);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      do @(posedge clock); while (!csr_ready);
      apply_reg(idx, d);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_bytes.size() != 0 || req_valid || expected_out.size() != 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   function automatic void build_msg(ref byte_item_type q[$], input int len, input int fill);
      byte_item_type it;
      for (int i = 0; i < len; i++) begin
         it.data = (fill == 1) ? 8'h00 : (fill == 2) ? 8'hff : 8'($urandom);
         it.last = (i == len - 1);
         q.push_back(it);
      end
   endfunction

   // dry run over one message to learn its tag; any message start rebuilds the state
   function automatic logic [63:0] tag_of(ref byte_item_type q[$]);
      cipher_out_type r;
      foreach (q[i]) r = encipher_byte(q[i]);
      return r.tag;
   endfunction

   function automatic logic [63:0] pick64();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin
      byte_item_type msg[$];
      int sent;
      int len;
      key_w = '{default: '0};
      salt_lo = '0;
      salt_hi = '0;
      decrypt = 1'b0;
      rx_tag = '0;
      base_pad = '0;
      chunk_pad = '0;
      chunk_no = '0;
      chunk_pos = '0;
      msg_len = '0;
      mac_chain = IV;
      mac_block = '0;
      msg_open = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset settings, one-byte messages of the extremes, a prefix-filling message
      build_msg(msg, 1, 1);
      build_msg(msg, 1, 2);
      for (int i = 0; i < 20; i++)
         msg.push_back('{(i % 2) ? 8'hff : 8'h00, i == 19});
      foreach (msg[i]) pending_bytes.push_back(msg[i]);
      sent = msg.size();
      wait_idle();

      // directed: all-ones key and salt, decrypt with a matching tag, spare indexes
      for (int i = 0; i < 4; i++) write_reg(4'(skxt_pkg::CSR_KEY0 + i), '1);
      write_reg(skxt_pkg::CSR_SALT_LOW, '1);
      write_reg(skxt_pkg::CSR_SALT_HIGH, 64'hffff_ffff);
      write_reg(skxt_pkg::CSR_DECRYPT, 64'd1);
      write_reg(CSR_SPARE_LO, {$urandom, $urandom});
      write_reg(CSR_SPARE_HI, '1);
      msg.delete();
      build_msg(msg, 2, 0);
      write_reg(skxt_pkg::CSR_EXP_TAG, tag_of(msg));
      foreach (msg[i]) pending_bytes.push_back(msg[i]);
      pending_bytes.push_back('{8'h5a, 1'b1});
      sent += 3;
      wait_idle();

      for (int phase = 0; sent < 1300; phase++) begin
         for (int i = 0; i < 4; i++) write_reg(4'(skxt_pkg::CSR_KEY0 + i), pick64());
         write_reg(skxt_pkg::CSR_SALT_LOW, pick64());
         write_reg(skxt_pkg::CSR_SALT_HIGH, {32'd0, 32'(pick64() >> 32)});
         write_reg(skxt_pkg::CSR_DECRYPT, 64'($urandom_range(0, 1)));
         msg.delete();
         build_msg(msg, $urandom_range(1, 70), 0);
         write_reg(skxt_pkg::CSR_EXP_TAG,
                   $urandom_range(0, 2) != 0 ? tag_of(msg) : pick64());
         if (phase == 0) hold_request = 1;
         for (int m = 0; m < 8; m++) begin
            case ($urandom_range(0, 9))
               0: len = $urandom_range(100, 300);
               1: len = $urandom_range(12, 20);
               default: len = $urandom_range(1, 70);
            endcase
            build_msg(msg, len, 0);
         end
         foreach (msg[i]) pending_bytes.push_back(msg[i]);
         sent += msg.size();
         wait_idle();
      end

      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

[filelist.f]
+incdir+design
design/skxt_pkg.sv
design/skxt_compress.sv
design/sha256_keystream_xor_tag.sv
sim/testbench.sv
